// ===== rtl/kbv_pkg.sv =====
package kbv_pkg;

    // Defaults for the top-level parameters
    localparam int KBV_CAP_MAX     = 255;
    localparam int KBV_VALUE_WIDTH = 24;

    // Fixed field widths
    localparam int KBV_CAP_W     = 8;
    localparam int KBV_WEIGHT_W  = 8;
    localparam int KBV_ITEM_VW   = 16;
    localparam int KBV_OUT_W     = 24;
    localparam logic [KBV_OUT_W-1:0] KBV_OUT_MAX = {KBV_OUT_W{1'b1}};

    // Item queue between front and back (power of two)
    localparam int KBV_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [KBV_WEIGHT_W-1:0] weight;
        logic [KBV_ITEM_VW-1:0]  value;
        logic                    last;
        logic                    heavy;  // weight above the table, no update
    } item_t;

endpackage

// ===== rtl/kbv_front.sv =====
module kbv_front #(
    parameter int CAP_MAX = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kbv_pkg::KBV_WEIGHT_W-1:0]    s_item_weight,
    input  logic [kbv_pkg::KBV_ITEM_VW-1:0]     s_item_value,
    input  logic                                s_last_item,
    output logic                                q_valid,
    input  logic                                q_ready,
    output kbv_pkg::item_t                      q_item
);
    import kbv_pkg::*;

    localparam int QD = KBV_QUEUE_DEPTH;
    localparam int PW = (QD > 1) ? $clog2(QD) : 1;
    localparam int CW = $clog2(QD + 1);

    item_t          slot_reg [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;
    item_t          in_item;

    always_comb begin
        in_item.weight = s_item_weight;
        in_item.value  = s_item_value;
        in_item.last   = s_last_item;
        in_item.heavy  = (32'(s_item_weight) > CAP_MAX);
    end

    assign s_ready = (count_reg != CW'(QD));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/kbv_back.sv =====
module kbv_back #(
    parameter int CAP_MAX     = 255,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [kbv_pkg::KBV_CAP_W-1:0]       capacity,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  kbv_pkg::item_t                      q_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kbv_pkg::KBV_OUT_W-1:0]       m_best_value
);
    import kbv_pkg::*;

    localparam int DEPTH = CAP_MAX + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int AW    = (IW > KBV_WEIGHT_W) ? IW : KBV_WEIGHT_W;
    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = ((VW > KBV_ITEM_VW) ? VW : KBV_ITEM_VW) + 1;
    localparam int OW    = (VW > KBV_OUT_W) ? VW : KBV_OUT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [VW-1:0]  mem [DEPTH];

    logic [1:0]             state_reg, state_next;
    logic [IW-1:0]          c_reg, c_next;
    logic [IW-1:0]          cap_reg;
    logic [KBV_WEIGHT_W-1:0] w_reg;
    logic [KBV_ITEM_VW-1:0] v_reg;
    logic                   last_reg;
    logic                   heavy_reg;
    logic                   fresh_reg, fresh_next;

    // read stage
    logic                   s1_valid_reg;
    logic [IW-1:0]          s1_addr_reg;
    logic                   s1_take_reg;
    logic                   s1_cap_reg;
    logic [VW-1:0]          rd_a_reg, rd_b_reg;

    logic [VW-1:0]          res_reg;
    logic                   m_valid_reg;
    logic [KBV_OUT_W-1:0]   m_value_reg;

    logic [AW-1:0]          c_ext, w_ext, diff;
    logic                   take_ok;
    logic [IW-1:0]          rb_addr;
    logic [IW-1:0]          cap_sel;
    logic [VW-1:0]          old_v, low_v, take_v, new_v, res_final;
    logic [SW-1:0]          sum;
    logic [OW-1:0]          res_ext;
    logic [KBV_OUT_W-1:0]   out_v;
    logic                   out_free, load_out;

    assign q_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_best_value = m_value_reg;

    // address generation
    always_comb begin
        c_ext   = AW'(c_reg);
        w_ext   = AW'(w_reg);
        diff    = c_ext - w_ext;
        take_ok = !heavy_reg && (c_ext >= w_ext);
        rb_addr = take_ok ? diff[IW-1:0] : '0;
        cap_sel = (32'(capacity) > CAP_MAX) ? IW'(CAP_MAX) : IW'(capacity);
    end

    // update: max(old, sat(low + value)); entries read as zero in a fresh set
    always_comb begin
        old_v  = fresh_reg ? '0 : rd_a_reg;
        low_v  = fresh_reg ? '0 : rd_b_reg;
        sum    = SW'(low_v) + SW'(v_reg);
        take_v = (sum > SW'({VW{1'b1}})) ? {VW{1'b1}} : sum[VW-1:0];
        new_v  = (s1_take_reg && (take_v > old_v)) ? take_v : old_v;
        res_final = (s1_valid_reg && s1_cap_reg) ? new_v : res_reg;
        res_ext   = OW'(res_final);
        out_v     = (res_ext > OW'(KBV_OUT_MAX)) ? KBV_OUT_MAX : res_ext[KBV_OUT_W-1:0];
    end

    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        load_out   = 1'b0;
        state_next = state_reg;
        c_next     = c_reg;
        fresh_next = fresh_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_RUN;
                    c_next     = IW'(CAP_MAX);
                end
            end
            ST_RUN: begin
                c_next = IW'(c_reg - 1'b1);
                if (c_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!last_reg || out_free) begin
                    state_next = ST_IDLE;
                    fresh_next = last_reg;
                    load_out   = last_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fresh_reg    <= 1'b1;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            c_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            fresh_reg    <= fresh_next;
            c_reg        <= c_next;
            s1_valid_reg <= (state_reg == ST_RUN);
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item registers, sampled when the item leaves the queue
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            w_reg     <= q_item.weight;
            v_reg     <= q_item.value;
            last_reg  <= q_item.last;
            heavy_reg <= q_item.heavy;
            cap_reg   <= cap_sel;
        end
        s1_addr_reg <= c_reg;
        s1_take_reg <= take_ok;
        s1_cap_reg  <= (c_reg == cap_reg);
        if (s1_valid_reg && s1_cap_reg) begin
            res_reg <= new_v;
        end
        if (load_out) begin
            m_value_reg <= out_v;
        end
    end

    // table: two registered reads, one write
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RUN) begin
            rd_a_reg <= mem[c_reg];
            rd_b_reg <= mem[rb_addr];
        end
        if (s1_valid_reg) begin
            mem[s1_addr_reg] <= new_v;
        end
    end

endmodule

// ===== rtl/knapsack_01_best_value_core.sv =====
// 0/1 knapsack best value over a stream of items.
//
// Channels:
//   cfg_*  : capacity write (valid/ready, always ready). Write only while idle.
//   s_*    : one item per handshake: weight, value, last-item flag.
//   m_*    : one result item per set, the best value for the capacity in force
//            when the last item of the set is processed (saturated at 24 bits).
// Throughput: each item makes one pass over the whole table, one entry per
//   cycle: a pickup state, an update of every entry from the top capacity
//   down, and a write-back state. The table memory's single write port
//   sets that rate.
// A two-item queue before the engine keeps s_ready high in a pass until full.
// Reset: queue and result register empty, capacity 0, table treated as empty;
//   the first pass of each set writes every entry, so no clearing pass exists.
// Stall: a result held on m_* waits for m_ready; the engine holds its next
//   result in the write-back state, and the queue fills and drops s_ready.
module knapsack_01_best_value_core #(
    parameter int CAP_MAX     = kbv_pkg::KBV_CAP_MAX,
    parameter int VALUE_WIDTH = kbv_pkg::KBV_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kbv_pkg::KBV_CAP_W-1:0]       cfg_capacity,
    // items in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kbv_pkg::KBV_WEIGHT_W-1:0]    s_item_weight,
    input  logic [kbv_pkg::KBV_ITEM_VW-1:0]     s_item_value,
    input  logic                                s_last_item,
    // results out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kbv_pkg::KBV_OUT_W-1:0]       m_best_value
);
    import kbv_pkg::*;

    logic [KBV_CAP_W-1:0] capacity_reg;
    logic                 q_valid, q_ready;
    item_t                q_item;

    // capacity register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= cfg_capacity;
        end
    end

    // front: accepts and tags items, buffers them
    kbv_front #(
        .CAP_MAX (CAP_MAX)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item_weight (s_item_weight),
        .s_item_value  (s_item_value),
        .s_last_item   (s_last_item),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // back: table pass per item, result register
    kbv_back #(
        .CAP_MAX     (CAP_MAX),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .capacity     (capacity_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_value (m_best_value)
    );

endmodule

// ===== rtl/kbv_checker.sv =====
module kbv_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_last_item,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [kbv_pkg::KBV_OUT_W-1:0]       m_best_value
);
    import kbv_pkg::*;

    // last items accepted whose result has not been taken yet
    logic [3:0] pend_reg;
    logic       s_last_acc, m_acc;

    assign s_last_acc = s_valid && s_ready && s_last_item;
    assign m_acc      = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (s_last_acc && !m_acc) begin
            pend_reg <= 4'(pend_reg + 1'b1);
        end else if (m_acc && !s_last_acc) begin
            pend_reg <= 4'(pend_reg - 1'b1);
        end
    end

    a_out_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pend_reg != '0))
        else $error("result without an accepted last item");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_value))
        else $error("stalled result dropped or changed");

    a_pend_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg >= 4'd4) |-> !s_ready || !s_valid || !s_last_item)
        else $error("too many sets in flight");

endmodule

bind knapsack_01_best_value_core kbv_checker u_kbv_checker (.*);

// ===== tb/knapsack_01_best_value_core_test.sv =====
`timescale 1ns / 100ps

module knapsack_01_best_value_core_test;

    import kbv_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int CAP_MAX    = KBV_CAP_MAX;
    localparam int VW         = KBV_VALUE_WIDTH;
    // one engine pass per item: pickup, an update of every entry, write-back
    localparam int ENGINE_PASS = CAP_MAX + 3;
    // queued items plus the one in the engine, plus margin
    localparam int SETTLE = (KBV_QUEUE_DEPTH + 2) * ENGINE_PASS;
    // overall time limit for the run, in ns
    localparam int LIMIT_NS = 2_500_000 * CLK_PERIOD;
    localparam int IDLE_PCT = 37;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [KBV_CAP_W-1:0]    cfg_capacity = '0;

    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [KBV_WEIGHT_W-1:0] s_item_weight = '0;
    logic [KBV_ITEM_VW-1:0]  s_item_value  = '0;
    logic                    s_last_item   = 1'b0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [KBV_OUT_W-1:0]    m_best_value;

    // Predictor state: best value per capacity, and the capacity in force
    logic [VW-1:0]        knap_tbl [0:CAP_MAX];
    logic [KBV_CAP_W-1:0] capacity_reg;

    // Best values still owed by the block, oldest first
    logic [KBV_OUT_W-1:0] pending_best [$];
    logic [KBV_OUT_W-1:0] owed;

    int  err_count;
    // 1 = neither side idles
    bit  steady;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    knapsack_01_best_value_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item_weight(s_item_weight),
        .s_item_value (s_item_value),
        .s_last_item  (s_last_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_value (m_best_value)
    );

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tb: %s at %0t: got %0d, want %0d", what, $realtime, got, want);
        err_count++;
    endtask

    // Fold one item into the table, top capacity first so each item is
    // counted once. On the last item, owe the entry at the capacity and
    // start a fresh set.
    task automatic fold_item(input int w, input int v, input bit last);
        logic [VW:0]   sum;
        logic [VW-1:0] best;
        int            idx;
        if (w <= CAP_MAX) begin
            for (int c = CAP_MAX; c >= w; c--) begin
                sum = {1'b0, knap_tbl[c - w]} + (VW + 1)'(v);
                // saturate at the table width
                if (sum[VW])
                    sum = {1'b0, {VW{1'b1}}};
                if (sum[VW-1:0] > knap_tbl[c])
                    knap_tbl[c] = sum[VW-1:0];
            end
        end
        if (last) begin
            idx  = (capacity_reg > CAP_MAX) ? CAP_MAX : int'(capacity_reg);
            best = knap_tbl[idx];
            if (best > KBV_OUT_MAX)
                pending_best.push_back(KBV_OUT_MAX);
            else
                pending_best.push_back(KBV_OUT_W'(best));
            foreach (knap_tbl[c])
                knap_tbl[c] = '0;
        end
    endtask

    // Send one item; s_valid stays up between back-to-back items.
    task automatic push_item(input int w, input int v, input bit last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_valid       <= 1'b1;
        s_item_weight <= KBV_WEIGHT_W'(w);
        s_item_value  <= KBV_ITEM_VW'(v);
        s_last_item   <= last;
        do @(posedge aclk); while (!s_ready);
        fold_item(w, v, last);
    endtask

    // Stop sending, let every owed result come out, then let the engine
    // finish any item that owes nothing.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_best.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_capacity(input int cap);
        wait_idle();
        cfg_valid    <= 1'b1;
        cfg_capacity <= KBV_CAP_W'(cap);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        capacity_reg  = KBV_CAP_W'(cap);
    endtask

    // Receiver: stalls at random unless in the steady stretch
    always @(posedge aclk)
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_best.size() == 0) begin
                report_mismatch("best_value with no set pending", m_best_value, 0);
            end else begin
                owed = pending_best.pop_front();
                if (m_best_value !== owed)
                    report_mismatch("best_value mismatch", m_best_value, owed);
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed tests
    // ---------------------------------------------------------------

    // Small set with a clear optimum: 3+5+2 fills 10, worth 16
    task automatic test_small_set();
        set_capacity(10);
        push_item(3, 5, 1'b0);
        push_item(4, 6, 1'b0);
        push_item(5, 8, 1'b0);
        push_item(2, 3, 1'b1);
    endtask

    // Weight and value at both ends, full capacity
    task automatic test_field_extremes();
        set_capacity(255);
        push_item(255, 65535, 1'b0);
        push_item(0, 0, 1'b0);
        push_item(0, 65535, 1'b0);
        push_item(255, 0, 1'b1);
    endtask

    // Capacity zero: only weightless items count, and they always do
    task automatic test_zero_capacity();
        set_capacity(0);
        push_item(0, 7, 1'b0);
        push_item(1, 100, 1'b0);
        push_item(0, 9, 1'b1);
    endtask

    // Items heavier than the capacity leave the answer alone
    task automatic test_heavy_item();
        set_capacity(100);
        push_item(101, 500, 1'b0);
        push_item(100, 40, 1'b1);
        push_item(255, 65535, 1'b1);
    endtask

    // The table covers every capacity, so the answer follows the capacity
    // in force when the last item arrives, even if changed mid-set.
    task automatic test_capacity_change_mid_set();
        set_capacity(5);
        push_item(5, 10, 1'b0);
        push_item(200, 1000, 1'b0);
        set_capacity(255);
        push_item(50, 1, 1'b1);
    endtask

    task automatic test_single_item_set();
        push_item(17, 1234, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // Random tests
    // ---------------------------------------------------------------

    // Light items of near-max value: the running sum passes 24 bits
    task automatic test_saturation();
        set_capacity(255);
        for (int i = 0; i < 300; i++)
            push_item($urandom_range(0, 1), $urandom_range(60000, 65535), i == 299);
    endtask

    // Sets of random length; capacity changes between some sets
    task automatic test_random_sets(input int n_items);
        int left;
        int len;
        int pick;
        int w;
        int v;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(99) < 40) begin
                pick = $urandom_range(9);
                set_capacity(pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(1, 254));
            end
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++) begin
                // mostly items that fit, some of any weight
                w = ($urandom_range(99) < 70) ? $urandom_range(0, capacity_reg)
                                              : $urandom_range(0, 255);
                pick = $urandom_range(9);
                v = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(0, 65535);
                push_item(w, v, i == len - 1);
            end
            left -= len;
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        err_count    = 0;
        steady       = 1'b0;
        capacity_reg = '0;
        foreach (knap_tbl[c])
            knap_tbl[c] = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_small_set();
        test_field_extremes();
        test_zero_capacity();
        test_heavy_item();
        test_capacity_change_mid_set();
        test_single_item_set();
        test_saturation();
        test_random_sets(350);
        steady = 1'b1;
        test_random_sets(250);
        steady = 1'b0;
        test_random_sets(330);

        wait_idle();
        if (pending_best.size() != 0)
            report_mismatch("best_values never delivered", pending_best.size(), 0);

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kbv_pkg.sv
rtl/kbv_front.sv
rtl/kbv_back.sv
rtl/knapsack_01_best_value_core.sv
rtl/kbv_checker.sv
tb/knapsack_01_best_value_core_test.sv
